FILE: rtl/u2l_pkg.sv
// ============================================================================
// u2l_pkg: shared types and constants for the UTF-8 to Latin-1 transcoder
// Request and result payloads, the run descriptor that the front passes to
// the back, and the code point to Latin-1 mapping function.
// ============================================================================
package u2l_pkg;

    // Most result bytes that one input request can cause.
    localparam int RUN_MAX       = 4;
    localparam int RUN_IDX_W     = $clog2(RUN_MAX);
    localparam int RUN_CNT_W     = $clog2(RUN_MAX + 1);
    localparam int CODE_W        = 21;
    localparam int RUN_Q_DEPTH   = 2;

    // Byte classes.
    localparam logic [7:0] CONT_MASK  = 8'hC0;
    localparam logic [7:0] CONT_TAG   = 8'h80;
    localparam logic [7:0] LEAD2_MASK = 8'hE0;
    localparam logic [7:0] LEAD2_TAG  = 8'hC0;
    localparam logic [7:0] LEAD3_MASK = 8'hF0;
    localparam logic [7:0] LEAD3_TAG  = 8'hE0;
    localparam logic [7:0] LEAD4_MASK = 8'hF8;
    localparam logic [7:0] LEAD4_TAG  = 8'hF0;

    // Sequence lengths, counted in continuation bytes.
    localparam logic [1:0] NEED_NONE = 2'd0;
    localparam logic [1:0] NEED_ONE  = 2'd1;
    localparam logic [1:0] NEED_TWO  = 2'd2;
    localparam logic [1:0] NEED_THREE = 2'd3;

    // Replacement bytes.
    localparam logic [7:0] CH_QUOTE1  = 8'h27;
    localparam logic [7:0] CH_QUOTE2  = 8'h22;
    localparam logic [7:0] CH_DASH    = 8'h2D;
    localparam logic [7:0] CH_BULLET  = 8'd149;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_EURO    = 8'd128;
    localparam logic [7:0] CH_LT      = 8'h3C;
    localparam logic [7:0] CH_GT      = 8'h3E;
    localparam logic [7:0] CH_CARET   = 8'h5E;
    localparam logic [7:0] CH_VEE     = 8'h76;
    localparam logic [7:0] CH_REG     = 8'd174;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_UNKNOWN = 8'h3F;

    // Input request: one text byte or the end marker.
    typedef struct packed {
        logic [7:0] in_byte;
        logic       is_end;
    } t_in_item;

    // One delivered result byte.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_in_run;
    } t_out_item;

    // All result bytes of one request, oldest in entry zero.
    typedef struct packed {
        logic [RUN_MAX-1:0][7:0] bytes;
        logic [RUN_CNT_W-1:0]    count;
    } t_run;

    // Map a complete code point to one Latin-1 byte.
    function automatic logic [7:0] map_code(input logic [CODE_W-1:0] cp);
        logic [7:0] res;
        res = CH_UNKNOWN;
        if (cp < 21'd256) begin
            res = cp[7:0];
        end else begin
            case (cp)
                21'h2018, 21'h2019, 21'h201B: res = CH_QUOTE1;
                21'h201C, 21'h201D, 21'h201F: res = CH_QUOTE2;
                21'h2013, 21'h2014, 21'h2212: res = CH_DASH;
                21'h2022: res = CH_BULLET;
                21'h2026: res = CH_DOT;
                21'h20AC: res = CH_EURO;
                21'h2190: res = CH_LT;
                21'h2192: res = CH_GT;
                21'h2191: res = CH_CARET;
                21'h2193: res = CH_VEE;
                21'h2122: res = CH_REG;
                default: begin
                    if (cp >= 21'h2000 && cp <= 21'h200F) begin
                        res = CH_SPACE;
                    end
                end
            endcase
        end
        return res;
    endfunction

endpackage

FILE: rtl/u2l_front.sv
// ============================================================================
// u2l_front: sequence decoder
// Accepts one request per clock on i_accept, tracks the pending multi-byte
// sequence and turns each request into a run of zero to four result bytes.
// ============================================================================
module u2l_front import u2l_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_accept,
    input  t_in_item i_item,
    output logic     o_run_valid,
    output t_run     o_run
);

    logic [7:0]        r_lead, n_lead;
    logic [1:0]        r_need, n_need;
    logic [1:0]        r_taken, n_taken;
    logic [CODE_W-1:0] r_acc, n_acc;

    logic [7:0]        in_b;
    logic              is_cont;
    logic [CODE_W-1:0] acc_shift;
    logic [1:0]        taken_inc;
    t_run              flush_run;
    t_run              run;

    assign in_b      = i_item.in_byte;
    assign is_cont   = (in_b & CONT_MASK) == CONT_TAG;
    assign acc_shift = {r_acc[CODE_W-7:0], in_b[5:0]};
    assign taken_inc = r_taken + 2'd1;

    // Raw bytes of the pending sequence: the lead, then rebuilt continuations.
    always_comb begin
        flush_run          = '0;
        flush_run.bytes[0] = r_lead;
        flush_run.count    = RUN_CNT_W'(r_taken) + RUN_CNT_W'(1);
        case (r_taken)
            2'd1: begin
                flush_run.bytes[1] = CONT_TAG | {2'b00, r_acc[5:0]};
            end
            2'd2: begin
                flush_run.bytes[1] = CONT_TAG | {2'b00, r_acc[11:6]};
                flush_run.bytes[2] = CONT_TAG | {2'b00, r_acc[5:0]};
            end
            default: begin
            end
        endcase
    end

    // Decode one request into a run and the next sequence state.
    always_comb begin
        n_lead  = r_lead;
        n_need  = r_need;
        n_taken = r_taken;
        n_acc   = r_acc;
        run     = '0;
        if (i_item.is_end) begin
            if (r_need != NEED_NONE) begin
                run     = flush_run;
                n_lead  = '0;
                n_need  = NEED_NONE;
                n_taken = '0;
                n_acc   = '0;
            end
        end else if (r_need != NEED_NONE && is_cont) begin
            if (taken_inc == r_need) begin
                run.bytes[0] = map_code(acc_shift);
                run.count    = RUN_CNT_W'(1);
                n_lead       = '0;
                n_need       = NEED_NONE;
                n_taken      = '0;
                n_acc        = '0;
            end else begin
                n_acc   = acc_shift;
                n_taken = taken_inc;
            end
        end else begin
            // A non-continuation breaks any pending sequence first.
            if (r_need != NEED_NONE) begin
                run = flush_run;
            end
            n_lead  = '0;
            n_need  = NEED_NONE;
            n_taken = '0;
            n_acc   = '0;
            // Then the byte is handled as a fresh one.
            if ((in_b & LEAD2_MASK) == LEAD2_TAG) begin
                n_lead = in_b;
                n_need = NEED_ONE;
                n_acc  = CODE_W'(in_b[4:0]);
            end else if ((in_b & LEAD3_MASK) == LEAD3_TAG) begin
                n_lead = in_b;
                n_need = NEED_TWO;
                n_acc  = CODE_W'(in_b[3:0]);
            end else if ((in_b & LEAD4_MASK) == LEAD4_TAG) begin
                n_lead = in_b;
                n_need = NEED_THREE;
                n_acc  = CODE_W'(in_b[2:0]);
            end else begin
                run.bytes[run.count[RUN_IDX_W-1:0]] = in_b;
                run.count = run.count + RUN_CNT_W'(1);
            end
        end
    end

    // Sequence state advances only on an accepted request.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lead  <= '0;
            r_need  <= NEED_NONE;
            r_taken <= '0;
            r_acc   <= '0;
        end else if (i_accept) begin
            r_lead  <= n_lead;
            r_need  <= n_need;
            r_taken <= n_taken;
            r_acc   <= n_acc;
        end
    end

    assign o_run_valid = i_accept && (run.count != '0);
    assign o_run       = run;

endmodule

FILE: rtl/u2l_queue.sv
// ============================================================================
// u2l_queue: run queue
// Short first-in first-out store of runs between the decoder and the
// result serializer.
// ============================================================================
module u2l_queue import u2l_pkg::*; #(
    parameter int DEPTH = RUN_Q_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_wr,
    input  t_run i_wr_run,
    input  logic i_rd,
    output logic o_full,
    output logic o_valid,
    output t_run o_head
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_run          r_mem [DEPTH];
    logic [AW-1:0] r_wp, n_wp;
    logic [AW-1:0] r_rp, n_rp;
    logic [CW-1:0] r_cnt, n_cnt;

    // Pointer and fill count update.
    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (i_wr) begin
            n_wp = (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + AW'(1);
        end
        if (i_rd) begin
            n_rp = (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + AW'(1);
        end
        if (i_wr && !i_rd) begin
            n_cnt = r_cnt + CW'(1);
        end else if (!i_wr && i_rd) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wp] <= i_wr_run;
        end
    end

    assign o_full  = r_cnt == CW'(DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_head  = r_mem[r_rp];

endmodule

FILE: rtl/u2l_back.sv
// ============================================================================
// u2l_back: result serializer
// Walks the bytes of the oldest run into a registered result slot, one per
// clock while the slot is empty or popped, and marks each run's last byte.
// ============================================================================
module u2l_back import u2l_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_run_valid,
    input  t_run      i_run,
    output logic      o_run_done,
    input  logic      i_pop,
    output logic      o_res_valid,
    output t_out_item o_res
);

    logic [RUN_IDX_W-1:0] r_idx, n_idx;
    logic                 r_valid, n_valid;
    t_out_item            r_res;
    logic                 load;
    logic                 is_last;

    // The slot takes a byte when it is empty or being drained this cycle.
    assign load    = i_run_valid && (!r_valid || i_pop);
    assign is_last = RUN_CNT_W'(r_idx) == (i_run.count - RUN_CNT_W'(1));

    always_comb begin
        n_idx   = r_idx;
        n_valid = r_valid;
        if (load) begin
            n_valid = 1'b1;
            n_idx   = is_last ? '0 : r_idx + RUN_IDX_W'(1);
        end else if (i_pop) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_idx   <= n_idx;
            r_valid <= n_valid;
        end
    end

    // Result payload register.
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_res.out_byte    <= i_run.bytes[r_idx];
            r_res.last_in_run <= is_last;
        end
    end

    assign o_run_done  = load && is_last;
    assign o_res_valid = r_valid;
    assign o_res       = r_res;

endmodule

FILE: rtl/utf8_to_latin1_transcoder.sv
// ============================================================================
// utf8_to_latin1_transcoder: UTF-8 to Latin-1 byte stream transcoder
// Decoder front, run queue and result serializer behind queue-style ports.
// ============================================================================
// The block takes one request per clock while full is low (a text byte or
// the end marker) and delivers one result byte per clock while pop is held
// high. A broken or flushed sequence yields up to four bytes, which the
// serializer drains at one per clock. The decoder is combinational and
// writes each run into the run queue at the edge that accepts its request.
// A run leaves the queue when its last byte is loaded. Push sees full while
// QUEUE_DEPTH runs wait in the queue, which happens behind such a burst or
// while pop is held low. When the serializer is idle, a result shows on
// o_result once its run has been written into the run queue and then loaded
// into the result register.
module utf8_to_latin1_transcoder import u2l_pkg::*; #(
    parameter int QUEUE_DEPTH = RUN_Q_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      push,
    output logic      full,
    input  t_in_item  i_item,
    output logic      empty,
    input  logic      pop,
    output t_out_item o_result
);

    logic      accept;
    logic      run_wr;
    t_run      run_new;
    logic      q_valid;
    t_run      q_head;
    logic      run_done;
    logic      res_valid;

    assign accept = push && !full;

    // Decoder front.
    u2l_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_item     (i_item),
        .o_run_valid(run_wr),
        .o_run      (run_new)
    );

    // Run queue between front and back.
    u2l_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (run_wr),
        .i_wr_run(run_new),
        .i_rd    (run_done),
        .o_full  (full),
        .o_valid (q_valid),
        .o_head  (q_head)
    );

    // Result serializer.
    u2l_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_run_valid(q_valid),
        .i_run      (q_head),
        .o_run_done (run_done),
        .i_pop      (pop && res_valid),
        .o_res_valid(res_valid),
        .o_res      (o_result)
    );

    assign empty = !res_valid;

endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps
// ============================================================================
// tb: self-checking bench for the UTF-8 to Latin-1 transcoder
// A scoreboard predicts the Latin-1 result bytes of every accepted request
// and compares each delivered result, field by field, in order. Stimulus is
// a directed list followed by random, mostly well-formed UTF-8 text with
// broken sequences, stray bytes and end markers mixed in. The sender idles
// in bursts and the receiver stalls on a changing pattern of its own.
// ============================================================================
module tb;
    import u2l_pkg::*;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      push = 1'b0;
    logic      full;
    t_in_item  i_item = '0;
    logic      empty;
    logic      pop = 1'b0;
    t_out_item o_result;

    utf8_to_latin1_transcoder dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_item   (i_item),
        .empty    (empty),
        .pop      (pop),
        .o_result (o_result)
    );

    always #1 i_clk = ~i_clk;

    // Predicts the result bytes of each request and checks delivered results.
    class latin1_scoreboard;
        t_out_item   expected_q[$];
        logic [7:0]  run_bytes[$];
        logic [7:0]  seq_lead;
        logic [1:0]  seq_need;
        logic [1:0]  seq_taken;
        logic [20:0] seq_code;
        int          errors;

        function new();
            errors = 0;
            clear_seq();
        endfunction

        function void clear_seq();
            seq_lead  = '0;
            seq_need  = NEED_NONE;
            seq_taken = '0;
            seq_code  = '0;
        endfunction

        // Latin-1 byte for a complete code point.
        function logic [7:0] latin1_of(logic [20:0] cp);
            logic [7:0] ch;
            if (cp < 21'd256) begin
                ch = cp[7:0];
            end else begin
                case (cp)
                    21'h2018, 21'h2019, 21'h201B: ch = 8'h27;
                    21'h201C, 21'h201D, 21'h201F: ch = 8'h22;
                    21'h2013, 21'h2014, 21'h2212: ch = 8'h2D;
                    21'h2022: ch = 8'd149;
                    21'h2026: ch = 8'h2E;
                    21'h20AC: ch = 8'd128;
                    21'h2190: ch = 8'h3C;
                    21'h2192: ch = 8'h3E;
                    21'h2191: ch = 8'h5E;
                    21'h2193: ch = 8'h76;
                    21'h2122: ch = 8'd174;
                    default: begin
                        if (cp >= 21'h2000 && cp <= 21'h200F) ch = 8'h20;
                        else ch = 8'h3F;
                    end
                endcase
            end
            return ch;
        endfunction

        // Emit the held lead byte and the continuations taken so far, raw.
        function void flush_seq();
            int k;
            k = seq_taken;
            run_bytes.push_back(seq_lead);
            for (int i = 0; i < k; i++) begin
                run_bytes.push_back(8'h80 | 8'((seq_code >> (6 * (k - 1 - i))) & 21'h3F));
            end
            clear_seq();
        endfunction

        function void note_request(t_in_item req);
            logic [7:0] b;
            logic       fresh;
            t_out_item  res;
            b = req.in_byte;
            fresh = 1'b1;
            run_bytes.delete();
            if (req.is_end) begin
                if (seq_need != NEED_NONE) flush_seq();
                fresh = 1'b0;
            end else if (seq_need != NEED_NONE) begin
                if ((b & CONT_MASK) == CONT_TAG) begin
                    fresh = 1'b0;
                    seq_code  = {seq_code[14:0], b[5:0]};
                    seq_taken = seq_taken + 2'd1;
                    if (seq_taken == seq_need) begin
                        run_bytes.push_back(latin1_of(seq_code));
                        clear_seq();
                    end
                end else begin
                    flush_seq();
                end
            end
            // A byte not consumed by a pending sequence starts afresh.
            if (fresh) begin
                if (b < 8'h80) begin
                    run_bytes.push_back(b);
                end else if ((b & LEAD2_MASK) == LEAD2_TAG) begin
                    seq_lead = b; seq_need = NEED_ONE; seq_taken = '0;
                    seq_code = 21'(b & 8'h1F);
                end else if ((b & LEAD3_MASK) == LEAD3_TAG) begin
                    seq_lead = b; seq_need = NEED_TWO; seq_taken = '0;
                    seq_code = 21'(b & 8'h0F);
                end else if ((b & LEAD4_MASK) == LEAD4_TAG) begin
                    seq_lead = b; seq_need = NEED_THREE; seq_taken = '0;
                    seq_code = 21'(b & 8'h07);
                end else begin
                    run_bytes.push_back(b);
                end
            end
            foreach (run_bytes[i]) begin
                res.out_byte    = run_bytes[i];
                res.last_in_run = (i == run_bytes.size() - 1);
                expected_q.push_back(res);
            end
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (expected_q.size() == 0) begin
                $error("unexpected result: out_byte %h last_in_run %b",
                       got.out_byte, got.last_in_run);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (got.out_byte !== want.out_byte) begin
                $error("out_byte: expected %h, got %h", want.out_byte, got.out_byte);
                errors++;
            end
            if (got.last_in_run !== want.last_in_run) begin
                $error("last_in_run: expected %b, got %b",
                       want.last_in_run, got.last_in_run);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    latin1_scoreboard sb = new();
    t_in_item         stim_q[$];
    int               text_bytes;

    // Code points with their own replacement, plus the ends of the space range and their neighbors.
    logic [20:0] special_cp[21] = '{
        21'h2018, 21'h2019, 21'h201B, 21'h201C, 21'h201D, 21'h201F,
        21'h2013, 21'h2014, 21'h2212, 21'h2022, 21'h2026, 21'h20AC,
        21'h2190, 21'h2191, 21'h2192, 21'h2193, 21'h2122,
        21'h2000, 21'h200F, 21'h1FFF, 21'h2010
    };

    // Receiver: the pop pattern changes between free-running and stall phases.
    int stall_left = 0;
    int stall_pct = 0;

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (stall_left == 0) begin
                stall_left = $urandom_range(8, 64);
                case ($urandom_range(0, 3))
                    0: stall_pct = 0;
                    1: stall_pct = 30;
                    2: stall_pct = 60;
                    default: stall_pct = 90;
                endcase
            end
            stall_left = stall_left - 1;
            pop <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // Check every result taken at a rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) sb.check_result(o_result);
    end

    task automatic add_byte(input logic [7:0] b);
        t_in_item req;
        req.in_byte = b;
        req.is_end  = 1'b0;
        stim_q.push_back(req);
        text_bytes++;
    endtask

    task automatic add_end();
        t_in_item req;
        req.in_byte = 8'($urandom);
        req.is_end  = 1'b1;
        stim_q.push_back(req);
    endtask

    // Queue the first n bytes of the len-byte encoding of cp.
    task automatic add_encoded(input int len, input logic [20:0] cp, input int n);
        logic [7:0] lead;
        int         conts;
        conts = len - 1;
        case (len)
            2: lead = LEAD2_TAG | 8'((cp >> 6) & 21'h1F);
            3: lead = LEAD3_TAG | 8'((cp >> 12) & 21'h0F);
            default: lead = LEAD4_TAG | 8'((cp >> 18) & 21'h07);
        endcase
        add_byte(lead);
        for (int i = 0; i < conts && i < n - 1; i++) begin
            add_byte(CONT_TAG | 8'((cp >> (6 * (conts - 1 - i))) & 21'h3F));
        end
    endtask

    task automatic add_random_text(input int n_bytes);
        int          len;
        int          k;
        logic [20:0] cp;
        logic [7:0]  b;
        while (text_bytes < n_bytes) begin
            len = $urandom_range(2, 4);
            cp  = 21'($urandom);
            if (len == 3 && $urandom_range(0, 1) == 1)
                cp = special_cp[$urandom_range(0, 20)];
            case ($urandom_range(0, 19))
                // Plain ASCII.
                0, 1, 2, 3, 4, 5: add_byte(8'($urandom_range(0, 127)));
                // Complete sequence with random content.
                6, 7, 8, 9, 10, 11, 12: add_encoded(len, cp, len);
                // Sequence cut short by a non-continuation byte or the end marker.
                13, 14: begin
                    k = $urandom_range(1, len - 1);
                    add_encoded(len, cp, k);
                    if ($urandom_range(0, 2) == 0) begin
                        add_end();
                    end else begin
                        do b = 8'($urandom);
                        while ((b & CONT_MASK) == CONT_TAG);
                        add_byte(b);
                    end
                end
                // Stray continuation or invalid lead byte.
                15, 16: begin
                    if ($urandom_range(0, 1) == 1) add_byte(8'($urandom_range(8'h80, 8'hBF)));
                    else add_byte(8'($urandom_range(8'hF8, 8'hFF)));
                end
                17: add_end();
                default: add_byte(8'($urandom));
            endcase
        end
    endtask

    // Offer one request until the block takes it.
    task automatic send_request(input t_in_item req);
        @(negedge i_clk);
        push   <= 1'b1;
        i_item <= req;
        do @(posedge i_clk);
        while (full);
        sb.note_request(req);
    endtask

    task automatic hold_off(input int n);
        repeat (n) begin
            @(negedge i_clk);
            push <= 1'b0;
        end
    endtask

    // Drive the queued requests in bursts, most of them followed by a random gap.
    task automatic run_stimulus();
        int burst;
        while (stim_q.size() > 0) begin
            burst = $urandom_range(1, 24);
            while (burst > 0 && stim_q.size() > 0) begin
                send_request(stim_q.pop_front());
                burst--;
            end
            if ($urandom_range(0, 3) != 0) hold_off($urandom_range(1, 6));
        end
    endtask

    // Hold the sender until all expected results have been delivered.
    task automatic wait_drained();
        hold_off(1);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    initial begin
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed requests: byte extremes, lone bytes, each sequence length,
        // replacements, a broken sequence and an end-marker flush.
        text_bytes = 0;
        add_byte(8'h00);
        add_byte(8'h7F);
        add_byte(8'h80);
        add_byte(8'hBF);
        add_byte(8'hF8);
        add_byte(8'hFF);
        add_encoded(2, 21'h0E9, 2);
        add_encoded(3, 21'h2019, 3);
        add_encoded(3, 21'h20AC, 3);
        add_encoded(4, 21'h1F600, 4);
        add_encoded(3, 21'h2000, 2);
        add_byte(8'h41);
        add_encoded(4, 21'h10000, 3);
        add_end();
        add_end();
        run_stimulus();
        wait_drained();

        // Random text in two halves with a full drain between them.
        text_bytes = 0;
        add_random_text(155);
        run_stimulus();
        wait_drained();
        text_bytes = 0;
        add_random_text(155);
        add_end();
        run_stimulus();
        wait_drained();

        if (sb.errors == 0) begin
            $display("[utf8_to_latin1_transcoder] OK");
        end else begin
            $display("[utf8_to_latin1_transcoder] ERROR");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #2000000;
        $display("[utf8_to_latin1_transcoder] ERROR");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/u2l_pkg.sv
rtl/u2l_front.sv
rtl/u2l_queue.sv
rtl/u2l_back.sv
rtl/utf8_to_latin1_transcoder.sv
bench/tb.sv
